@@ hdl/mfsm_pkg.sv @@
// types and constants shared by the multicast frame slot manager
// no dependencies; used by every module of the block
package mfsm_pkg;

	localparam int NUM_SLOTS     = 8;
	localparam int MAX_CONSUMERS = 4;
	localparam int SLOT_W        = 3;
	localparam int CONS_W        = 2;
	localparam int TAG_W         = 32;
	localparam int CNT_W         = 4;
	localparam int NCONS_W       = 3;

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_POP     = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NO_CONSUMERS = 3'd1,
		ST_NO_FREE      = 3'd2,
		ST_EMPTY        = 3'd3,
		ST_BAD_CONSUMER = 3'd4,
		ST_NOT_IN_USE   = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [CONS_W-1:0] consumer;
		logic [TAG_W-1:0]  frame_tag;
		logic [SLOT_W-1:0] slot;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] slot_out;
		logic [TAG_W-1:0]  tag_out;
		logic              slot_freed;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		logic              is_push;
		logic              is_pop;
		logic              is_release;
		logic [CONS_W-1:0] consumer;
		logic [TAG_W-1:0]  tag;
		logic [SLOT_W-1:0] slot;
	} op_t;

endpackage

@@ hdl/mfsm_front.sv @@
// front end: accepts commands, decodes them and holds them in a two entry queue
// depends on mfsm_pkg
module mfsm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mfsm_pkg::in_item_t in_item,
	output logic              op_valid,
	input  logic              op_ready,
	output mfsm_pkg::op_t     op
);

	mfsm_pkg::op_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	mfsm_pkg::op_t dec;
	logic          push_en;
	logic          pop_en;

	always_comb begin
		dec            = '0;
		dec.consumer   = in_item.consumer;
		dec.tag        = in_item.frame_tag;
		dec.slot       = in_item.slot;
		case (mfsm_pkg::cmd_code_t'(in_item.cmd))
			mfsm_pkg::CMD_PUSH:    dec.is_push = 1'b1;
			mfsm_pkg::CMD_POP:     dec.is_pop = 1'b1;
			mfsm_pkg::CMD_RELEASE: dec.is_release = 1'b1;
			default:               dec.is_push = 1'b0;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign op_valid = (count_q != 2'd0);
	assign op       = entry_q[rd_ptr_q];
	assign push_en  = in_valid && in_ready;
	assign pop_en   = op_valid && op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_en) wr_ptr_q <= ~wr_ptr_q;
			if (pop_en) rd_ptr_q <= ~rd_ptr_q;
			if (push_en && !pop_en) count_q <= count_q + 2'd1;
			else if (pop_en && !push_en) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) entry_q[wr_ptr_q] <= dec;
	end

endmodule

@@ hdl/mfsm_back.sv @@
// back end: slot pool, reference counts, consumer queues and result register
// depends on mfsm_pkg
module mfsm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mfsm_pkg::NCONS_W-1:0]  active_cons,
	input  logic                          op_valid,
	output logic                          op_ready,
	input  mfsm_pkg::op_t                 op,
	output logic                          res_valid,
	input  logic                          res_ready,
	output mfsm_pkg::out_item_t           res_item
);

	localparam int NS = mfsm_pkg::NUM_SLOTS;
	localparam int NC = mfsm_pkg::MAX_CONSUMERS;
	localparam int SW = mfsm_pkg::SLOT_W;
	localparam int CW = mfsm_pkg::CNT_W;

	logic [mfsm_pkg::TAG_W-1:0] slot_tag_q [NS];
	logic [SW-1:0]              slot_refs_q [NS];
	logic [SW-1:0]              free_fifo_q [NS];
	logic [SW-1:0]              free_head_q;
	logic [CW-1:0]              free_count_q;
	logic [SW-1:0]              q_store_q [NC][NS];
	logic [SW-1:0]              q_head_q [NC];
	logic [CW-1:0]              q_count_q [NC];
	logic                       res_valid_q;
	mfsm_pkg::out_item_t        res_q;

	logic                fire;
	logic                do_push;
	logic                do_pop;
	logic                do_rel;
	logic                rel_free;
	logic [SW-1:0]       push_slot;
	logic [SW-1:0]       pop_slot;
	logic [SW-1:0]       refs_dec;
	logic [NC-1:0]       append;
	mfsm_pkg::out_item_t res_d;

	assign op_ready  = !res_valid_q || res_ready;
	assign fire      = op_valid && op_ready;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	assign push_slot = free_fifo_q[free_head_q];
	assign pop_slot  = q_store_q[op.consumer][q_head_q[op.consumer]];
	assign refs_dec  = slot_refs_q[op.slot] - 3'd1;

	always_comb begin
		res_d    = '0;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		do_rel   = 1'b0;
		rel_free = 1'b0;
		if (op.is_push) begin
			if (active_cons == '0) begin
				res_d.status = mfsm_pkg::ST_NO_CONSUMERS;
			end else if (free_count_q == '0) begin
				res_d.status = mfsm_pkg::ST_NO_FREE;
			end else begin
				do_push        = 1'b1;
				res_d.slot_out = push_slot;
				res_d.tag_out  = op.tag;
			end
		end else if (op.is_pop) begin
			if ({1'b0, op.consumer} >= active_cons) begin
				res_d.status = mfsm_pkg::ST_BAD_CONSUMER;
			end else if (q_count_q[op.consumer] == '0) begin
				res_d.status = mfsm_pkg::ST_EMPTY;
			end else begin
				do_pop         = 1'b1;
				res_d.slot_out = pop_slot;
				res_d.tag_out  = slot_tag_q[pop_slot];
			end
		end else if (op.is_release) begin
			if (slot_refs_q[op.slot] == '0) begin
				res_d.status = mfsm_pkg::ST_NOT_IN_USE;
			end else begin
				do_rel   = 1'b1;
				rel_free = (refs_dec == '0) && (free_count_q < CW'(NS));
				res_d.slot_freed = rel_free;
			end
		end
		for (int c = 0; c < NC; c++) begin
			append[c] = do_push && (c < int'(active_cons)) && (q_count_q[c] < CW'(NS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			free_head_q  <= '0;
			free_count_q <= CW'(NS);
			for (int i = 0; i < NS; i++) begin
				slot_refs_q[i] <= '0;
				free_fifo_q[i] <= SW'(i);
			end
			for (int c = 0; c < NC; c++) begin
				q_head_q[c]  <= '0;
				q_count_q[c] <= '0;
			end
		end else begin
			if (fire) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			if (fire && do_push) begin
				free_head_q            <= free_head_q + 3'd1;
				free_count_q           <= free_count_q - 4'd1;
				slot_refs_q[push_slot] <= active_cons;
			end
			if (fire && do_rel) begin
				slot_refs_q[op.slot] <= refs_dec;
				if (rel_free) begin
					free_fifo_q[free_head_q + free_count_q[SW-1:0]] <= op.slot;
					free_count_q <= free_count_q + 4'd1;
				end
			end
			if (fire && do_pop) begin
				q_head_q[op.consumer]  <= q_head_q[op.consumer] + 3'd1;
				q_count_q[op.consumer] <= q_count_q[op.consumer] - 4'd1;
			end
			for (int c = 0; c < NC; c++) begin
				if (fire && append[c]) q_count_q[c] <= q_count_q[c] + 4'd1;
			end
		end
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (fire) res_q <= res_d;
		if (fire && do_push) slot_tag_q[push_slot] <= op.tag;
		for (int c = 0; c < NC; c++) begin
			if (fire && append[c])
				q_store_q[c][q_head_q[c] + q_count_q[c][SW-1:0]] <= push_slot;
		end
	end

endmodule

@@ hdl/multicast_frame_slot_manager_unit.sv @@
// top level of the multicast frame slot manager: front end, command queue, back end
// depends on mfsm_pkg, mfsm_front, mfsm_back
//
//  channel | signals                     | payload
//  --------+-----------------------------+-------------------------------
//  command | cmd_valid / cmd_ready       | cmd  (cmd, consumer, frame_tag, slot)
//  result  | res_valid / res_ready       | res  (status, slot_out, tag_out, slot_freed)
//  config  | cfg_we                      | cfg_data (num_consumers)
//
// every command yields one result; an accepted command goes into the decode queue
// and then the result register, one command per cycle sustained while res_ready is high
// the back end updates the whole pool state together for each command it takes
// the two entry queue lets commands keep arriving while a result is stalled
// reset restores the free list to slots in order, clears counts and queues at once
module multicast_frame_slot_manager_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  mfsm_pkg::in_item_t           cmd,
	output logic                         res_valid,
	input  logic                         res_ready,
	output mfsm_pkg::out_item_t          res,
	input  logic                         cfg_we,
	input  logic [mfsm_pkg::NCONS_W-1:0] cfg_data
);

	logic [mfsm_pkg::NCONS_W-1:0] num_consumers_q;
	logic [mfsm_pkg::NCONS_W-1:0] active_cons;
	logic                         op_valid;
	logic                         op_ready;
	mfsm_pkg::op_t                op;

	// consumer count register; the user writes it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_consumers_q <= '0;
		end else if (cfg_we) begin
			num_consumers_q <= cfg_data;
		end
	end

	// counts above the supported number of consumers act as the maximum
	assign active_cons = (num_consumers_q > mfsm_pkg::NCONS_W'(mfsm_pkg::MAX_CONSUMERS))
		? mfsm_pkg::NCONS_W'(mfsm_pkg::MAX_CONSUMERS) : num_consumers_q;

	// decode and queue
	mfsm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_valid),
		.in_ready (cmd_ready),
		.in_item  (cmd),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	// pool state and result register
	mfsm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.active_cons (active_cons),
		.op_valid    (op_valid),
		.op_ready    (op_ready),
		.op          (op),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_item    (res)
	);

endmodule

@@ hdl/mfsm_checker.sv @@
// port level checks for the multicast frame slot manager, bound to the top level
// depends on mfsm_pkg
module mfsm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input mfsm_pkg::out_item_t res
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result dropped or changed while stalled");

	// a freed slot only comes from a successful release
	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.slot_freed |-> res.status == mfsm_pkg::ST_OK
			&& res.slot_out == '0 && res.tag_out == '0)
		else $error("slot freed with bad fields");

	// failed commands report no slot and no tag
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != mfsm_pkg::ST_OK |->
			res.slot_out == '0 && res.tag_out == '0 && !res.slot_freed)
		else $error("error result carries payload");

	// status codes stay within the defined set
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.status <= 3'd5)
		else $error("undefined status");

endmodule

bind multicast_frame_slot_manager_unit mfsm_checker u_mfsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

@@ dv/tb_multicast_frame_slot_manager_unit.sv @@
// self-checking testbench for the multicast frame slot manager
// depends on mfsm_pkg and multicast_frame_slot_manager_unit
// a scoreboard class models the slot pool and checks every result transfer
module tb_multicast_frame_slot_manager_unit;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 8;

	// slot pool model and store of pending result predictions
	class slot_pool_board;
		logic [mfsm_pkg::TAG_W-1:0]   tag_mem [mfsm_pkg::NUM_SLOTS];
		logic [mfsm_pkg::NCONS_W-1:0] refs [mfsm_pkg::NUM_SLOTS];
		logic [mfsm_pkg::SLOT_W-1:0]  free_list [mfsm_pkg::NUM_SLOTS];
		logic [mfsm_pkg::SLOT_W-1:0]  free_rd;
		logic [mfsm_pkg::CNT_W-1:0]   free_cnt;
		logic [mfsm_pkg::SLOT_W-1:0]  cq [mfsm_pkg::MAX_CONSUMERS][mfsm_pkg::NUM_SLOTS];
		logic [mfsm_pkg::SLOT_W-1:0]  cq_head [mfsm_pkg::MAX_CONSUMERS];
		logic [mfsm_pkg::CNT_W-1:0]   cq_cnt [mfsm_pkg::MAX_CONSUMERS];
		logic [mfsm_pkg::NCONS_W-1:0] n_cons;
		mfsm_pkg::out_item_t pending_results[$];
		int errors;

		function new();
			errors = 0;
			n_cons = '0;
			free_rd = '0;
			free_cnt = mfsm_pkg::CNT_W'(mfsm_pkg::NUM_SLOTS);
			for (int i = 0; i < mfsm_pkg::NUM_SLOTS; i++) begin
				refs[i] = '0;
				free_list[i] = mfsm_pkg::SLOT_W'(i);
				tag_mem[i] = '0;
			end
			for (int c = 0; c < mfsm_pkg::MAX_CONSUMERS; c++) begin
				cq_head[c] = '0;
				cq_cnt[c] = '0;
			end
		endfunction

		function int active();
			return (n_cons > mfsm_pkg::MAX_CONSUMERS) ? mfsm_pkg::MAX_CONSUMERS : int'(n_cons);
		endfunction

		// predict the result of one accepted command
		function void note_command(mfsm_pkg::in_item_t it);
			mfsm_pkg::out_item_t r;
			logic [mfsm_pkg::SLOT_W-1:0] s;
			int n;
			r = '0;
			r.status = mfsm_pkg::ST_OK;
			n = active();
			case (it.cmd)
				mfsm_pkg::CMD_PUSH: begin
					if (n == 0) begin
						r.status = mfsm_pkg::ST_NO_CONSUMERS;
					end else if (free_cnt == 0) begin
						r.status = mfsm_pkg::ST_NO_FREE;
					end else begin
						s = free_list[free_rd];
						free_rd = free_rd + 3'd1;
						free_cnt = free_cnt - 4'd1;
						tag_mem[s] = it.frame_tag;
						refs[s] = mfsm_pkg::NCONS_W'(n);
						for (int c = 0; c < n; c++) begin
							if (cq_cnt[c] < mfsm_pkg::NUM_SLOTS) begin
								cq[c][mfsm_pkg::SLOT_W'(cq_head[c] + cq_cnt[c])] = s;
								cq_cnt[c] = cq_cnt[c] + 4'd1;
							end
						end
						r.slot_out = s;
						r.tag_out = it.frame_tag;
					end
				end
				mfsm_pkg::CMD_POP: begin
					if (it.consumer >= n) begin
						r.status = mfsm_pkg::ST_BAD_CONSUMER;
					end else if (cq_cnt[it.consumer] == 0) begin
						r.status = mfsm_pkg::ST_EMPTY;
					end else begin
						s = cq[it.consumer][cq_head[it.consumer]];
						cq_head[it.consumer] = cq_head[it.consumer] + 3'd1;
						cq_cnt[it.consumer] = cq_cnt[it.consumer] - 4'd1;
						r.slot_out = s;
						r.tag_out = tag_mem[s];
					end
				end
				mfsm_pkg::CMD_RELEASE: begin
					s = it.slot;
					if (refs[s] == 0) begin
						r.status = mfsm_pkg::ST_NOT_IN_USE;
					end else begin
						refs[s] = refs[s] - 3'd1;
						if (refs[s] == 0 && free_cnt < mfsm_pkg::NUM_SLOTS) begin
							free_list[mfsm_pkg::SLOT_W'(free_rd + free_cnt)] = s;
							free_cnt = free_cnt + 4'd1;
							r.slot_freed = 1'b1;
						end
					end
				end
				default: ;
			endcase
			pending_results.insert(pending_results.size(), r);
		endfunction

		// compare one result transfer with the oldest prediction
		function void check_result(mfsm_pkg::out_item_t got);
			mfsm_pkg::out_item_t exp_r;
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer status=%0d", got.status);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (got.status !== exp_r.status) begin
				$error("status: expected %0d actual %0d", exp_r.status, got.status);
				errors++;
			end
			if (got.slot_out !== exp_r.slot_out) begin
				$error("slot_out: expected %0d actual %0d", exp_r.slot_out, got.slot_out);
				errors++;
			end
			if (got.tag_out !== exp_r.tag_out) begin
				$error("tag_out: expected %h actual %h", exp_r.tag_out, got.tag_out);
				errors++;
			end
			if (got.slot_freed !== exp_r.slot_freed) begin
				$error("slot_freed: expected %0d actual %0d", exp_r.slot_freed,
					got.slot_freed);
				errors++;
			end
		endfunction

		// a slot held by some consumer if one is found within 16 tries, for well-formed releases
		function logic [mfsm_pkg::SLOT_W-1:0] pick_used_slot();
			int tries;
			logic [mfsm_pkg::SLOT_W-1:0] s;
			s = '0;
			for (tries = 0; tries < 16; tries++) begin
				s = mfsm_pkg::SLOT_W'($urandom_range(mfsm_pkg::NUM_SLOTS - 1));
				if (refs[s] != 0) return s;
			end
			return s;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	mfsm_pkg::in_item_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	mfsm_pkg::out_item_t res;
	logic cfg_we = 1'b0;
	logic [mfsm_pkg::NCONS_W-1:0] cfg_data = '0;

	slot_pool_board board = new();

	// idle percentages per phase, 0 means no idling
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_cycles = 0;
	int idle_cycles = 0;

	always #2 clk = ~clk;

	multicast_frame_slot_manager_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	// result side: check each transfer, stall at random, honor a long hold-off
	always @(posedge clk) begin
		if (res_valid && res_ready)
			board.check_result(res);
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// offer one command and wait for its transfer
	task automatic send_command(mfsm_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= it;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		board.note_command(it);
	endtask

	task automatic send_fields(mfsm_pkg::cmd_code_t c, int cons,
		logic [mfsm_pkg::TAG_W-1:0] tag, int s);
		mfsm_pkg::in_item_t it;
		it.cmd = c;
		it.consumer = mfsm_pkg::CONS_W'(cons);
		it.frame_tag = tag;
		it.slot = mfsm_pkg::SLOT_W'(s);
		send_command(it);
	endtask

	// wait until every prediction is met, then let the pipe settle
	task automatic drain_results();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic set_consumers(int n);
		cfg_we <= 1'b1;
		cfg_data <= mfsm_pkg::NCONS_W'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
		board.n_cons = mfsm_pkg::NCONS_W'(n);
		@(posedge clk);
	endtask

	// random traffic: mostly push/pop/release of live slots, some noise
	task automatic random_traffic(int count);
		mfsm_pkg::in_item_t it;
		int pick;
		for (int i = 0; i < count; i++) begin
			it.frame_tag = $urandom();
			it.consumer = mfsm_pkg::CONS_W'($urandom_range(3));
			it.slot = mfsm_pkg::SLOT_W'($urandom_range(7));
			pick = $urandom_range(99);
			if (pick < 35) begin
				it.cmd = mfsm_pkg::CMD_PUSH;
			end else if (pick < 65) begin
				it.cmd = mfsm_pkg::CMD_POP;
				if (board.active() > 0 && pick < 60)
					it.consumer = mfsm_pkg::CONS_W'($urandom_range(board.active() - 1));
			end else if (pick < 95) begin
				it.cmd = mfsm_pkg::CMD_RELEASE;
				if (pick < 88) it.slot = board.pick_used_slot();
			end else begin
				it.cmd = mfsm_pkg::CMD_NONE;
			end
			send_command(it);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no consumers, bad consumer, empty queue, release of free slot
		send_fields(mfsm_pkg::CMD_PUSH, 0, 32'hFFFF_FFFF, 0);
		send_fields(mfsm_pkg::CMD_POP, 0, 0, 0);
		send_fields(mfsm_pkg::CMD_RELEASE, 0, 0, 7);
		send_fields(mfsm_pkg::CMD_NONE, 3, 32'hFFFF_FFFF, 7);
		drain_results();
		set_consumers(7); // above the maximum acts as all consumers
		send_fields(mfsm_pkg::CMD_POP, 3, 0, 0);
		for (int i = 0; i < 9; i++)
			send_fields(mfsm_pkg::CMD_PUSH, 0,
				(i == 0) ? 32'h0 : 32'hFFFF_FFF0 + 32'(i), 0);
		send_fields(mfsm_pkg::CMD_POP, 3, 0, 0);
		send_fields(mfsm_pkg::CMD_POP, 0, 0, 0);
		send_fields(mfsm_pkg::CMD_RELEASE, 0, 0, 0);
		send_fields(mfsm_pkg::CMD_RELEASE, 0, 0, 0);
		send_fields(mfsm_pkg::CMD_RELEASE, 0, 0, 0);
		send_fields(mfsm_pkg::CMD_RELEASE, 0, 0, 0);
		send_fields(mfsm_pkg::CMD_RELEASE, 0, 0, 0);
		send_fields(mfsm_pkg::CMD_PUSH, 0, 32'h5555_AAAA, 0); // queues of consumers 1 and 2 are full
		drain_results();

		// no idling, max consumers
		set_consumers(4);
		random_traffic(200);
		drain_results();

		// sender idle, single consumer
		set_consumers(1);
		send_idle_pct = 69;
		random_traffic(200);
		drain_results();

		// receiver stalls, two consumers; long hold-off fills the pipe
		set_consumers(2);
		send_idle_pct = 0;
		recv_stall_pct = 69;
		hold_off_cycles = 60;
		random_traffic(200);
		drain_results();

		// both idle, three consumers
		set_consumers(3);
		send_idle_pct = 31;
		recv_stall_pct = 31;
		random_traffic(200);
		drain_results();

		// back to zero consumers briefly, then max again
		set_consumers(0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_traffic(30);
		drain_results();
		set_consumers(4);
		random_traffic(100);
		drain_results();

		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
